### hw/rtl/tgr_pkg.sv
package tgr_pkg;

  // Default coordinate width of a touch sample.
  localparam int COORD_BITS_DEF = 12;

  // Width and reset value of the swipe threshold register.
  localparam int          THRESH_W     = 12;
  localparam logic [11:0] THRESH_RESET = 12'd30;

  localparam int KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    EV_PRESS   = 3'd0,
    EV_DRAG    = 3'd1,
    EV_RELEASE = 3'd2,
    EV_LEFT    = 3'd3,
    EV_RIGHT   = 3'd4,
    EV_UP      = 3'd5,
    EV_DOWN    = 3'd6
  } event_kind_e;

  // Number of words pushed into the output queue in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
  } oq_push_t;

  // Room left in the output queue once this cycle's pop is counted.
  typedef struct packed {
    logic [1:0] free;
  } oq_stat_t;

endpackage

### hw/rtl/touch_gesture_recognizer_top.sv
// Channel   Direction  tdata                          tuser        tlast
// s_axis    in         sample_x, sample_y             touch_down   -
// m_axis    out        event_x, event_y, move_x,      event_kind   final_of_run
//                      move_y
// cfg       in         swipe_threshold (write only)   -            -
//
// A sample is taken into an input register and evaluated in the next cycle, where its
// events are pushed into a two-word output queue once it has room for all. One sample per
// cycle is sustained while each gives one event and the output is ready; a release that
// also gives a swipe waits in the input register until the queue has room for both words,
// as the output passes one word per cycle. Reset clears the gesture state and sets the
// threshold to 30. A stalled output fills the queue and then stalls the input side.
module touch_gesture_recognizer_top
  import tgr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_wr_en_i,
  input  logic [THRESH_W-1:0]                    cfg_wr_data_i,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // sample_x, sample_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata_i,
  // touch_down
  input  logic                                   s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // event_x, event_y, move_x, move_y, zero padding
  output logic [((4*COORD_BITS+2+7)/8)*8-1:0]    m_axis_tdata_o,
  // event_kind
  output logic [KIND_W-1:0]                      m_axis_tuser_o,
  // final_of_run
  output logic                                   m_axis_tlast_o
);

  localparam int C      = COORD_BITS;
  localparam int MW     = C + 1;
  localparam int PAY_W  = 4 * C + 2;
  localparam int DOUT_W = ((PAY_W + 7) / 8) * 8;
  localparam int ENT_W  = PAY_W + KIND_W + 1;
  localparam int CMP_W  = (C > THRESH_W) ? C : THRESH_W;

  // Input register.
  logic         in_vld_q;
  logic         in_down_q;
  logic [C-1:0] in_x_q, in_y_q;

  // Gesture state and threshold.
  logic                held_q, held_d;
  logic [C-1:0]        last_x_q, last_x_d, last_y_q, last_y_d;
  logic [C-1:0]        org_x_q, org_x_d, org_y_q, org_y_d;
  logic [THRESH_W-1:0] thr_q;

  logic [MW-1:0]    step_x, step_y, tot_x, tot_y;
  logic [MW-1:0]    neg_x, neg_y;
  logic [C-1:0]     abs_x, abs_y;
  logic             swipe;
  event_kind_e      swipe_kind;
  logic [1:0]       nres;
  logic             fire;
  logic [ENT_W-1:0] ent0, ent1, head;
  oq_push_t         oq_push;
  oq_stat_t         oq_stat;

  assign s_axis_tready_o = !in_vld_q || fire;

  assign step_x = {1'b0, in_x_q} - {1'b0, last_x_q};
  assign step_y = {1'b0, in_y_q} - {1'b0, last_y_q};
  assign tot_x  = {1'b0, last_x_q} - {1'b0, org_x_q};
  assign tot_y  = {1'b0, last_y_q} - {1'b0, org_y_q};
  assign neg_x  = -tot_x;
  assign neg_y  = -tot_y;
  assign abs_x  = tot_x[C] ? neg_x[C-1:0] : tot_x[C-1:0];
  assign abs_y  = tot_y[C] ? neg_y[C-1:0] : tot_y[C-1:0];
  assign swipe  = (CMP_W'(abs_x) > CMP_W'(thr_q)) || (CMP_W'(abs_y) > CMP_W'(thr_q));

  always_comb begin
    // The larger component picks the axis, ties go vertical.
    if (abs_x > abs_y) begin
      swipe_kind = tot_x[C] ? EV_LEFT : EV_RIGHT;
    end else begin
      swipe_kind = ((tot_y != '0) && !tot_y[C]) ? EV_DOWN : EV_UP;
    end
  end

  always_comb begin
    if (in_down_q) begin
      nres = 2'd1;
    end else if (held_q) begin
      nres = swipe ? 2'd2 : 2'd1;
    end else begin
      nres = 2'd0;
    end
  end

  assign fire        = in_vld_q && (nres <= oq_stat.free);
  assign oq_push.cnt = fire ? nres : 2'd0;

  // Queue words: {final_of_run, event_kind, move_y, move_x, event_y, event_x}.
  always_comb begin
    held_d   = held_q;
    last_x_d = last_x_q;
    last_y_d = last_y_q;
    org_x_d  = org_x_q;
    org_y_d  = org_y_q;
    ent0     = {1'b1, EV_RELEASE, {MW{1'b0}}, {MW{1'b0}}, last_y_q, last_x_q};
    ent1     = {1'b1, EV_RELEASE, {MW{1'b0}}, {MW{1'b0}}, last_y_q, last_x_q};
    if (in_down_q) begin
      held_d   = 1'b1;
      last_x_d = in_x_q;
      last_y_d = in_y_q;
      if (!held_q) begin
        org_x_d = in_x_q;
        org_y_d = in_y_q;
        ent0    = {1'b1, EV_PRESS, {MW{1'b0}}, {MW{1'b0}}, in_y_q, in_x_q};
      end else begin
        ent0    = {1'b1, EV_DRAG, step_y, step_x, in_y_q, in_x_q};
      end
    end else begin
      held_d = 1'b0;
      if (swipe) begin
        ent0 = {1'b0, swipe_kind, tot_y, tot_x, last_y_q, last_x_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      held_q   <= 1'b0;
      last_x_q <= '0;
      last_y_q <= '0;
      org_x_q  <= '0;
      org_y_q  <= '0;
      thr_q    <= THRESH_RESET;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (fire) begin
        held_q   <= held_d;
        last_x_q <= last_x_d;
        last_y_q <= last_y_d;
        org_x_q  <= org_x_d;
        org_y_q  <= org_y_d;
      end
      if (cfg_wr_en_i) begin
        thr_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_down_q <= s_axis_tuser_i;
      in_x_q    <= s_axis_tdata_i[C-1:0];
      in_y_q    <= s_axis_tdata_i[2*C-1:C];
    end
  end

  tgr_outq #(
    .W(ENT_W)
  ) u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (oq_push),
    .data0_i(ent0),
    .data1_i(ent1),
    .stat_o (oq_stat),
    .ready_i(m_axis_tready_i),
    .valid_o(m_axis_tvalid_o),
    .data_o (head)
  );

  assign m_axis_tdata_o = DOUT_W'(head[PAY_W-1:0]);
  assign m_axis_tuser_o = head[PAY_W+KIND_W-1:PAY_W];
  assign m_axis_tlast_o = head[ENT_W-1];

  a_swipe_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == EV_LEFT || m_axis_tuser_o == EV_RIGHT ||
      m_axis_tuser_o == EV_UP || m_axis_tuser_o == EV_DOWN) |-> !m_axis_tlast_o)
    else $error("swipe word marked as last of its run");

  a_press_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_down_q |=> held_q)
    else $error("contact not held after a pressed sample");

  a_lift_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !in_down_q |=> !held_q)
    else $error("contact still held after a lift sample");

  a_pair_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_push.cnt == 2'd2 |-> oq_stat.free == 2'd2)
    else $error("two events pushed without room for both");

endmodule

### hw/rtl/tgr_outq.sv
module tgr_outq
  import tgr_pkg::*;
#(
  parameter int W = 56
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  oq_push_t     push_i,
  input  logic [W-1:0] data0_i,
  input  logic [W-1:0] data1_i,
  output oq_stat_t     stat_o,
  input  logic         ready_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [1:0]   cnt_q, cnt_d;
  logic [W-1:0] ent_q [2];
  logic [W-1:0] ent_d [2];
  logic         pop;
  logic [1:0]   base;

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = ent_q[0];
  assign pop     = valid_o & ready_i;
  assign base    = cnt_q - {1'b0, pop};

  always_comb begin
    ent_d[0] = pop ? ent_q[1] : ent_q[0];
    ent_d[1] = ent_q[1];
    if (push_i.cnt != 2'd0) begin
      if (base == 2'd0) begin
        ent_d[0] = data0_i;
      end else begin
        ent_d[1] = data0_i;
      end
    end
    // Two words only ever arrive when the queue is about to be empty.
    if (push_i.cnt == 2'd2) begin
      ent_d[1] = data1_i;
    end
    cnt_d       = base + push_i.cnt;
    stat_o.free = 2'd2 - base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

endmodule
